// ===== rtl/b2da_pkg.sv =====
package b2da_pkg;

    // input value width and number of decimal digits it can need
    localparam int IN_WIDTH   = 16;
    localparam int NUM_DIGITS = 5;

    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;
    localparam int CNT_W   = $clog2(IN_WIDTH);
    localparam int POS_W   = $clog2(NUM_DIGITS);

    // ascii code of '0'
    localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;

    // control shared by every cell of the chain
    typedef struct packed {
        logic clear;
        logic dabble;
        logic advance;
    } cell_ctrl_t;

endpackage

// ===== rtl/b2da_cell.sv =====
module b2da_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  b2da_pkg::cell_ctrl_t                ctrl,
    input  logic                                bit_in,
    input  logic [b2da_pkg::DIGIT_W-1:0]        digit_in,
    output logic                                bit_out,
    output logic [b2da_pkg::DIGIT_W-1:0]        digit
);

    logic [b2da_pkg::DIGIT_W-1:0] digit_reg;
    logic [b2da_pkg::DIGIT_W-1:0] digit_next;
    logic [b2da_pkg::DIGIT_W-1:0] adjusted;

    // add three when the digit would overflow on the next doubling
    assign adjusted = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign bit_out  = adjusted[b2da_pkg::DIGIT_W-1];
    assign digit    = digit_reg;

    // next digit: clear, shift in one bit, take the neighbor's digit, or hold
    always_comb
    begin
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adjusted[b2da_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.advance)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    // each cell always holds a valid decimal digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_reg <= 4'd9)
        else $error("cell digit out of decimal range");

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Converts an unsigned 16-bit number into its decimal ASCII digits, most
// significant first, with leading zeros dropped (zero gives a single '0').
// A request is taken when start is high while busy is low. The value is
// shifted one bit at a time through a chain of five BCD digit cells, then
// the chain advances one digit a cycle through all five positions, for any
// value. Each character appears on digit_char for exactly one cycle with
// strobe high, one to five per request, and last_digit marks the final one;
// the receiver must take every strobed character as it comes, since nothing
// holds it. Busy falls in the cycle that strobes the last character, so the
// next request may start then.
module binary_to_decimal_ascii (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [b2da_pkg::IN_WIDTH-1:0]      number_value,
    output logic                               strobe,
    output logic [b2da_pkg::CHAR_W-1:0]        digit_char,
    output logic                               last_digit
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    state_t                               state_reg;
    logic [b2da_pkg::IN_WIDTH-1:0]        bin_reg;
    logic [b2da_pkg::CNT_W-1:0]           count_reg;
    logic [b2da_pkg::POS_W-1:0]           pos_reg;
    logic                                 started_reg;
    logic                                 strobe_reg;
    logic [b2da_pkg::CHAR_W-1:0]          digit_char_reg;
    logic                                 last_digit_reg;

    b2da_pkg::cell_ctrl_t                 ctrl;
    logic [b2da_pkg::NUM_DIGITS-1:0]      bit_chain;
    logic [b2da_pkg::DIGIT_W-1:0]         digits [b2da_pkg::NUM_DIGITS];
    logic [b2da_pkg::DIGIT_W-1:0]         top_digit;
    logic                                 take;
    logic                                 last_pos;
    logic                                 emit_now;

    assign take      = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign top_digit = digits[b2da_pkg::NUM_DIGITS-1];
    assign last_pos  = (pos_reg == b2da_pkg::POS_W'(b2da_pkg::NUM_DIGITS - 1));
    assign emit_now  = (state_reg == ST_EMIT)
                       && ((top_digit != '0) || started_reg || last_pos);

    // chain control
    always_comb
    begin
        ctrl.clear   = take;
        ctrl.dabble  = (state_reg == ST_CONVERT);
        ctrl.advance = (state_reg == ST_EMIT);
    end

    // digit cells, index 0 is the ones digit
    for (genvar i = 0; i < b2da_pkg::NUM_DIGITS; i++)
    begin : g_cell
        logic                         cell_bit_in;
        logic [b2da_pkg::DIGIT_W-1:0] cell_digit_in;

        if (i == 0)
        begin : g_first
            assign cell_bit_in   = bin_reg[b2da_pkg::IN_WIDTH-1];
            assign cell_digit_in = '0;
        end
        else
        begin : g_rest
            assign cell_bit_in   = bit_chain[i-1];
            assign cell_digit_in = digits[i-1];
        end

        b2da_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .bit_in   (cell_bit_in),
            .digit_in (cell_digit_in),
            .bit_out  (bit_chain[i]),
            .digit    (digits[i])
        );
    end

    // sequencer and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bin_reg        <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            started_reg    <= 1'b0;
            strobe_reg     <= 1'b0;
            digit_char_reg <= '0;
            last_digit_reg <= 1'b0;
        end
        else
        begin
            strobe_reg     <= emit_now;
            last_digit_reg <= emit_now && last_pos;
            digit_char_reg <= b2da_pkg::DIGIT_BASE + b2da_pkg::CHAR_W'(top_digit);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        bin_reg     <= number_value;
                        count_reg   <= '0;
                        pos_reg     <= '0;
                        started_reg <= 1'b0;
                        state_reg   <= ST_CONVERT;
                    end
                end
                ST_CONVERT:
                begin
                    bin_reg   <= {bin_reg[b2da_pkg::IN_WIDTH-2:0], 1'b0};
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == b2da_pkg::CNT_W'(b2da_pkg::IN_WIDTH - 1))
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_now)
                    begin
                        started_reg <= 1'b1;
                    end
                    pos_reg <= pos_reg + 1'b1;
                    if (last_pos)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign strobe     = strobe_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

    // strobed characters are decimal digits
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (digit_char >= b2da_pkg::DIGIT_BASE)
                   && (digit_char <= b2da_pkg::DIGIT_BASE + 6'd9))
        else $error("character outside '0' to '9'");

    // last flag only on a strobed character
    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        last_digit |-> strobe)
        else $error("last_digit without strobe");

    // once a run starts, characters follow without gaps until the last
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_digit |=> strobe)
        else $error("gap inside a digit run");

    // a taken request makes the block busy
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !strobe)
        else $error("request taken but block not busy");

endmodule
